>>> rtl/psb_pkg.sv
// shared types, constants and codes for the point submap binning block
package psb_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int GRID_CELLS_DEF = 65536;
   localparam int DIV_BITS       = 32;
   localparam int BOUND_BITS     = 24;
   localparam int SIZE_BITS      = 16;
   localparam int AXIS_BITS      = BOUND_BITS + 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 2 * BOUND_BITS;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [SIZE_BITS-1:0]     SIZE_RESET   = 16'd1280;
   localparam logic [SIZE_BITS-1:0]     MARGIN_RESET = 16'd128;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_OUT    = 2'd1;
   localparam logic [1:0] ST_HALTED = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SIZE_X   = 3'd0,
      REG_SIZE_Y   = 3'd1,
      REG_SIZE_Z   = 3'd2,
      REG_MARGIN   = 3'd3,
      REG_BOUNDS_X = 3'd4,
      REG_BOUNDS_Y = 3'd5,
      REG_BOUNDS_Z = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [2:0][SIZE_BITS-1:0]     size;
      logic [SIZE_BITS-1:0]          margin;
      logic [2:0][CSR_DATA_BITS-1:0] bounds;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [31:0]               pn;
      logic [2:0][AXIS_BITS-1:0] rel;
      logic [2:0][AXIS_BITS-1:0] n;
      logic [2:0]                lo_off;
      logic [2:0]                hi_off;
   } queue_entry_type;

   typedef struct packed {
      logic        last;
      logic [1:0]  status;
      logic        first;
      logic        home;
      logic        fresh;
      logic [15:0] slot;
      logic [15:0] cell_idx;
      logic [31:0] pn;
   } result_type;

endpackage

>>> rtl/point_submap_binning_with_margin.sv
// top level of the point submap binning block with overlap margin
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | req_tdata: coord_x, coord_y, coord_z
//  rsp     | out       | rsp_tvalid/tready    | rsp_tdata, rsp_tuser (status), rsp_tlast
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
//  a point passes the front through the three 32-step floor dividers;
//  the first point after a register write also rebins the bounds through them.
//  the back looks up each neighbour cell in its slot table walk.
//  after reset the slot table is cleared one entry a cycle, all GRID_CELLS entries,
//  with req_tready low; a stalled rsp holds the back, and the queue holds the front.
module point_submap_binning_with_margin import psb_pkg::*; #(
   parameter int GRID_CELLS = GRID_CELLS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,  // coord_x, coord_y, coord_z
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // point_number, cell_index, slot_number, new_slot, home_cell, first_home_point
   output logic [71:0]                   rsp_tdata,
   output logic [1:0]                    rsp_tuser,  // status
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   cfg_type         cfg_ff, cfg_in;
   queue_entry_type push_data, pop_data;
   result_type      rsp_data;
   logic            push_valid, push_ready, pop_valid, pop_ready, clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_SIZE_X:   cfg_in.size[0]   = csr_data[SIZE_BITS-1:0];
            REG_SIZE_Y:   cfg_in.size[1]   = csr_data[SIZE_BITS-1:0];
            REG_SIZE_Z:   cfg_in.size[2]   = csr_data[SIZE_BITS-1:0];
            REG_MARGIN:   cfg_in.margin    = csr_data[SIZE_BITS-1:0];
            REG_BOUNDS_X: cfg_in.bounds[0] = csr_data;
            REG_BOUNDS_Y: cfg_in.bounds[1] = csr_data;
            REG_BOUNDS_Z: cfg_in.bounds[2] = csr_data;
            default:      cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size   <= {SIZE_RESET, SIZE_RESET, SIZE_RESET};
         cfg_ff.margin <= MARGIN_RESET;
         cfg_ff.bounds <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   psb_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cfg_write  (csr_valid),
      .hold       (clearing),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .coord_x    (req_tdata[COORD_BITS-1:0]),
      .coord_y    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .coord_z    (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   psb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   psb_back #(.GRID_CELLS(GRID_CELLS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {5'b0, rsp_data.first, rsp_data.home, rsp_data.fresh,
                       rsp_data.slot, rsp_data.cell_idx, rsp_data.pn};
   assign rsp_tuser = rsp_data.status;
   assign rsp_tlast = rsp_data.last;

endmodule

>>> rtl/psb_fdiv.sv
// radix-2 floor divider of a signed value by an unsigned cell size
module psb_fdiv import psb_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DIV_BITS-1:0]  dividend,
   input  logic [SIZE_BITS-1:0]        divisor,
   output logic                        done,
   output logic signed [DIV_BITS-1:0]  quotient,
   output logic [SIZE_BITS-1:0]        remainder
);

   localparam int CNT_BITS = $clog2(DIV_BITS);

   logic                  busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]   mag_ff, mag_in;
   logic [SIZE_BITS-1:0]  rem_ff, rem_in, div_ff, div_in;
   logic [SIZE_BITS:0]    trial, diff;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, mag_ff[DIV_BITS-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend < 0;
         mag_in  = (dividend < 0) ? DIV_BITS'(-dividend) : DIV_BITS'(dividend);
         rem_in  = '0;
         cnt_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         mag_in = {mag_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   always_comb begin
      done = done_ff;
      if (!neg_ff) begin
         quotient  = $signed(mag_ff);
         remainder = rem_ff;
      end else if (rem_ff == '0) begin
         quotient  = -$signed(mag_ff);
         remainder = '0;
      end else begin
         quotient  = -$signed(mag_ff) - 1;
         remainder = div_ff - rem_ff;
      end
   end

endmodule

>>> rtl/psb_front.sv
// front end: bounds check, halt flag, floor division and margin classification
module psb_front import psb_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  cfg_write,
   input  logic                  hold,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] coord_x,
   input  logic [COORD_BITS-1:0] coord_y,
   input  logic [COORD_BITS-1:0] coord_z,
   output logic                  push_valid,
   input  logic                  push_ready,
   output queue_entry_type       push_data
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   typedef enum logic [2:0] {
      PH_LO = 3'b001,
      PH_HI = 3'b010,
      PH_PT = 3'b100
   } phase_type;

   front_state_type state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic            halted_ff, halted_in, grid_ok_ff, grid_ok_in;
   logic [31:0]     pcount_ff, pcount_in;
   queue_entry_type entry_ff, entry_in;
   logic [2:0][AXIS_BITS-1:0] n_ff, n_in;
   logic signed [DIV_BITS-1:0] point_ff [3];
   logic signed [DIV_BITS-1:0] point_in [3];
   logic signed [DIV_BITS-1:0] imin_ff [3];
   logic signed [DIV_BITS-1:0] imin_in [3];

   logic signed [DIV_BITS-1:0] pt [3];
   logic signed [DIV_BITS-1:0] lo [3];
   logic signed [DIV_BITS-1:0] hi [3];
   logic signed [DIV_BITS-1:0] div_arg [3];
   logic signed [DIV_BITS-1:0] div_q [3];
   logic signed [DIV_BITS-1:0] span [3];
   logic [SIZE_BITS-1:0]       size [3];
   logic [SIZE_BITS-1:0]       div_r [3];
   logic [SIZE_BITS:0]         upper_gap;
   logic [2:0]                 div_done;
   logic                       div_start, oob, accept;

   for (genvar a = 0; a < 3; a++) begin : g_div
      psb_fdiv u_fdiv (
         .clock     (clock),
         .reset     (reset),
         .start     (div_start),
         .dividend  (div_arg[a]),
         .divisor   (size[a]),
         .done      (div_done[a]),
         .quotient  (div_q[a]),
         .remainder (div_r[a])
      );
   end

   always_comb begin
      pt[0] = DIV_BITS'($signed(coord_x));
      pt[1] = DIV_BITS'($signed(coord_y));
      pt[2] = DIV_BITS'($signed(coord_z));
      oob   = 1'b0;
      for (int a = 0; a < 3; a++) begin
         lo[a]   = DIV_BITS'($signed(cfg.bounds[a][2*BOUND_BITS-1:BOUND_BITS]));
         hi[a]   = DIV_BITS'($signed(cfg.bounds[a][BOUND_BITS-1:0]));
         size[a] = (cfg.size[a] == '0) ? SIZE_BITS'(1) : cfg.size[a];
         if (pt[a] < lo[a] || pt[a] > hi[a]) oob = 1'b1;
      end
   end

   always_comb begin
      req_ready  = (state_ff == F_IDLE) && !hold;
      accept     = req_valid && req_ready;
      push_valid = (state_ff == F_PUSH);
      push_data  = entry_ff;
      state_in   = state_ff;
      phase_in   = phase_ff;
      halted_in  = halted_ff;
      grid_ok_in = grid_ok_ff;
      pcount_in  = pcount_ff;
      entry_in   = entry_ff;
      n_in       = n_ff;
      div_start  = 1'b0;
      upper_gap  = '0;
      for (int a = 0; a < 3; a++) begin
         point_in[a] = point_ff[a];
         imin_in[a]  = imin_ff[a];
         div_arg[a]  = point_ff[a];
         span[a]     = div_q[a] - imin_ff[a];
      end
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               for (int a = 0; a < 3; a++) point_in[a] = pt[a];
               entry_in = '0;
               if (halted_ff) begin
                  entry_in.status = ST_HALTED;
                  state_in        = F_PUSH;
               end else if (oob) begin
                  entry_in.status = ST_OUT;
                  halted_in       = 1'b1;
                  state_in        = F_PUSH;
               end else begin
                  entry_in.status = ST_OK;
                  div_start       = 1'b1;
                  for (int a = 0; a < 3; a++) div_arg[a] = grid_ok_ff ? pt[a] : lo[a];
                  phase_in = grid_ok_ff ? PH_PT : PH_LO;
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (div_done[0]) begin
               case (phase_ff)
                  PH_LO: begin
                     for (int a = 0; a < 3; a++) begin
                        imin_in[a] = div_q[a];
                        div_arg[a] = hi[a];
                     end
                     div_start = 1'b1;
                     phase_in  = PH_HI;
                  end
                  PH_HI: begin
                     for (int a = 0; a < 3; a++) n_in[a] = AXIS_BITS'(span[a] + 1);
                     grid_ok_in = 1'b1;
                     div_start  = 1'b1;
                     phase_in   = PH_PT;
                  end
                  PH_PT: begin
                     for (int a = 0; a < 3; a++) begin
                        entry_in.rel[a]    = AXIS_BITS'(span[a]);
                        entry_in.n[a]      = n_ff[a];
                        upper_gap          = {1'b0, size[a]} - {1'b0, div_r[a]};
                        entry_in.lo_off[a] = div_r[a] < cfg.margin;
                        entry_in.hi_off[a] = !(div_r[a] < cfg.margin) &&
                                             (upper_gap < {1'b0, cfg.margin});
                     end
                     entry_in.pn = pcount_ff;
                     pcount_in   = pcount_ff + 1'b1;
                     state_in    = F_PUSH;
                  end
                  default: phase_in = PH_PT;
               endcase
            end
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
      if (cfg_write) grid_ok_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         phase_ff   <= PH_PT;
         halted_ff  <= 1'b0;
         grid_ok_ff <= 1'b0;
         pcount_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         halted_ff  <= halted_in;
         grid_ok_ff <= grid_ok_in;
         pcount_ff  <= pcount_in;
      end
      entry_ff <= entry_in;
      n_ff     <= n_in;
      for (int a = 0; a < 3; a++) begin
         point_ff[a] <= point_in[a];
         imin_ff[a]  <= imin_in[a];
      end
   end

endmodule

>>> rtl/psb_fifo.sv
// short queue of classified points between front and back
module psb_fifo import psb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_data,
   output logic            pop_valid,
   input  logic            pop_ready,
   output queue_entry_type pop_data
);

   localparam int PTR_BITS = $clog2(DEPTH);

   queue_entry_type     mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      push_ready = count_ff != (PTR_BITS + 1)'(DEPTH);
      pop_valid  = count_ff != '0;
      pop_data   = mem_ff[rptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wptr_in    = do_push ? ((wptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1)
                           : wptr_ff;
      rptr_in    = do_pop ? ((rptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1)
                          : rptr_ff;
      count_in   = count_ff + (PTR_BITS + 1)'(do_push) - (PTR_BITS + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) mem_ff[wptr_ff] <= push_data;
   end

endmodule

>>> rtl/psb_back.sv
// back end: neighbour walk, cell index, slot table and home counts, result staging
module psb_back import psb_pkg::*; #(
   parameter int GRID_CELLS = GRID_CELLS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   output logic            clearing,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  queue_entry_type pop_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output result_type      rsp_data
);

   localparam int GRID_BITS = $clog2(GRID_CELLS);
   localparam int M1 = 2 * AXIS_BITS + 1;
   localparam int M2 = GRID_BITS + AXIS_BITS + 1;
   localparam logic [M1-1:0]        LIM1      = M1'(GRID_CELLS);
   localparam logic [M2-1:0]        LIM2      = M2'(GRID_CELLS);
   localparam logic [GRID_BITS-1:0] LAST_CELL = GRID_BITS'(GRID_CELLS - 1);

   typedef enum logic [11:0] {
      B_CLEAR = 12'b000000000001,
      B_IDLE  = 12'b000000000010,
      B_STAT  = 12'b000000000100,
      B_GEN   = 12'b000000001000,
      B_MUL1  = 12'b000000010000,
      B_MUL2  = 12'b000000100000,
      B_CHK   = 12'b000001000000,
      B_TRD   = 12'b000010000000,
      B_CRD   = 12'b000100000000,
      B_EMIT  = 12'b001000000000,
      B_ADV   = 12'b010000000000,
      B_FIN   = 12'b100000000000
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [GRID_BITS-1:0] clr_ff, clr_in, next_slot_ff, next_slot_in;
   logic [GRID_BITS-1:0] lin_ff, lin_in, slot_ff, slot_in;
   queue_entry_type      cur_ff, cur_in;
   logic [2:0]           step_ff, step_in;
   logic [AXIS_BITS-1:0] ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic                 home_ff, home_in, new_ff, new_in, fh_ff, fh_in;
   logic [M1-1:0]        mul1_ff, mul1_in;
   logic [M2-1:0]        mul2_ff, mul2_in;
   result_type           pend_ff, pend_in, out_ff, out_in;
   logic                 pend_valid_ff, pend_valid_in, out_valid_ff, out_valid_in;

   logic [GRID_BITS:0]   tbl_mem [GRID_CELLS];
   logic [GRID_BITS:0]   tbl_q, tbl_wdata;
   logic [GRID_BITS-1:0] tbl_waddr, tbl_raddr;
   logic                 tbl_we;
   logic [31:0]          cnt_mem [GRID_CELLS];
   logic [31:0]          cnt_q, cnt_wdata, cval;
   logic                 cnt_we;

   logic [AXIS_BITS:0]           c [3];
   logic [2:0]                   ok;
   logic [2*AXIS_BITS-1:0]       prod1;
   logic [GRID_BITS+AXIS_BITS-1:0] prod2;
   logic [2:0]                   span;
   logic                         out_free;
   result_type                   res;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         c[a]  = {1'b0, cur_ff.rel[a]} + (AXIS_BITS + 1)'(step_ff[a])
               - (AXIS_BITS + 1)'(cur_ff.lo_off[a]);
         ok[a] = !c[a][AXIS_BITS] && (c[a][AXIS_BITS-1:0] < cur_ff.n[a]);
      end
      span  = cur_ff.lo_off | cur_ff.hi_off;
      prod1 = iz_ff * cur_ff.n[1];
      prod2 = mul1_ff[GRID_BITS-1:0] * cur_ff.n[0];
      out_free = !out_valid_ff || rsp_ready;

      res          = '0;
      res.pn       = cur_ff.pn;
      res.cell_idx = 16'(lin_ff);
      res.slot     = 16'(slot_ff);
      res.fresh    = new_ff;
      res.home     = home_ff;
      res.first    = fh_ff;
      res.status   = ST_OK;

      cval      = new_ff ? '0 : cnt_q;
      cnt_wdata = !home_ff ? '0 : (&cval) ? cval : cval + 1'b1;
      cnt_we    = 1'b0;
      tbl_we    = 1'b0;
      tbl_waddr = lin_ff;
      tbl_wdata = {1'b1, next_slot_ff};
      tbl_raddr = mul2_ff[GRID_BITS-1:0];

      state_in      = state_ff;
      clr_in        = clr_ff;
      next_slot_in  = next_slot_ff;
      lin_in        = lin_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      step_in       = step_ff;
      ix_in         = ix_ff;
      iy_in         = iy_ff;
      iz_in         = iz_ff;
      home_in       = home_ff;
      new_in        = new_ff;
      fh_in         = fh_ff;
      mul1_in       = mul1_ff;
      mul2_in       = mul2_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      pop_ready     = 1'b0;

      case (state_ff)
         B_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            tbl_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_CELL) state_in = B_IDLE;
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_in   = pop_data;
               step_in  = '0;
               state_in = (pop_data.status == ST_OK) ? B_GEN : B_STAT;
            end
         end
         B_STAT: begin
            if (out_free) begin
               out_in        = '0;
               out_in.status = cur_ff.status;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               state_in      = B_IDLE;
            end
         end
         B_GEN: begin
            ix_in    = c[0][AXIS_BITS-1:0];
            iy_in    = c[1][AXIS_BITS-1:0];
            iz_in    = c[2][AXIS_BITS-1:0];
            home_in  = step_ff == cur_ff.lo_off;
            state_in = (&ok) ? B_MUL1 : B_ADV;
         end
         B_MUL1: begin
            mul1_in  = {1'b0, prod1} + M1'(iy_ff);
            state_in = B_MUL2;
         end
         B_MUL2: begin
            mul2_in  = {1'b0, prod2} + M2'(ix_ff);
            state_in = (mul1_ff < LIM1) ? B_CHK : B_ADV;
         end
         B_CHK: begin
            lin_in   = mul2_ff[GRID_BITS-1:0];
            state_in = (mul2_ff < LIM2) ? B_TRD : B_ADV;
         end
         B_TRD: begin
            new_in = !tbl_q[GRID_BITS];
            if (!tbl_q[GRID_BITS]) begin
               slot_in      = next_slot_ff;
               tbl_we       = 1'b1;
               next_slot_in = next_slot_ff + 1'b1;
            end else begin
               slot_in = tbl_q[GRID_BITS-1:0];
            end
            fh_in    = 1'b0;
            state_in = (home_ff || !tbl_q[GRID_BITS]) ? B_CRD : B_EMIT;
         end
         B_CRD: begin
            fh_in    = home_ff && (cval == '0);
            cnt_we   = 1'b1;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (!pend_valid_ff) begin
               pend_in       = res;
               pend_valid_in = 1'b1;
               state_in      = B_ADV;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_valid_in  = 1'b1;
               pend_in       = res;
               state_in      = B_ADV;
            end
         end
         B_ADV: begin
            state_in = B_GEN;
            if (span[2] && !step_ff[2]) begin
               step_in[2] = 1'b1;
            end else if (span[1] && !step_ff[1]) begin
               step_in[2:1] = 2'b01;
            end else if (span[0] && !step_ff[0]) begin
               step_in = 3'b001;
            end else begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            if (!pend_valid_ff) begin
               state_in = B_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      tbl_q <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[slot_ff] <= cnt_wdata;
      cnt_q <= cnt_mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         clr_ff        <= '0;
         next_slot_ff  <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         next_slot_ff  <= next_slot_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      lin_ff  <= lin_in;
      slot_ff <= slot_in;
      cur_ff  <= cur_in;
      step_ff <= step_in;
      ix_ff   <= ix_in;
      iy_ff   <= iy_in;
      iz_ff   <= iz_in;
      home_ff <= home_in;
      new_ff  <= new_in;
      fh_ff   <= fh_in;
      mul1_ff <= mul1_in;
      mul2_ff <= mul2_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign clearing  = state_ff == B_CLEAR;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> test/tb_point_submap_binning_with_margin.sv
// testbench for point_submap_binning_with_margin: random and directed points against a predictor
module tb_point_submap_binning_with_margin;
   import psb_pkg::*;

   localparam int  GRID     = 65536;
   localparam int  SETTLE   = 400;
   localparam longint LIMIT = 3000000;

   class binning_scoreboard;
      bit [15:0]   size_cfg [3];
      bit [15:0]   margin_cfg;
      bit [47:0]   bounds_cfg [3];
      int unsigned slot_of [int];
      int unsigned home_count [int];
      int unsigned next_slot;
      bit [31:0]   point_count;
      bit          halted;
      result_type  pending [$];

      function new();
         foreach (size_cfg[a]) size_cfg[a] = SIZE_RESET;
         margin_cfg = MARGIN_RESET;
         foreach (bounds_cfg[a]) bounds_cfg[a] = '0;
         next_slot = 0;
         point_count = 0;
         halted = 0;
      endfunction

      function void write_reg(reg_index_type idx, bit [47:0] value);
         case (idx)
            REG_SIZE_X:   size_cfg[0] = value[15:0];
            REG_SIZE_Y:   size_cfg[1] = value[15:0];
            REG_SIZE_Z:   size_cfg[2] = value[15:0];
            REG_MARGIN:   margin_cfg = value[15:0];
            REG_BOUNDS_X: bounds_cfg[0] = value;
            REG_BOUNDS_Y: bounds_cfg[1] = value;
            REG_BOUNDS_Z: bounds_cfg[2] = value;
            default: ;
         endcase
      endfunction

      static function longint floor_div(longint a, longint s);
         longint q;
         q = a / s;
         if (a % s != 0 && a < 0) q--;
         return q;
      endfunction

      function void note_point(bit [23:0] coord [3]);
         result_type r;
         result_type cells [$];
         longint p [3], n [3], rel [3], lo, hi, s, h, base, ix, iy, iz, lin;
         int lo_off [3], hi_off [3];
         bit [31:0] pn;
         r = '0;
         r.last = 1;
         if (halted) begin
            r.status = ST_HALTED;
            pending = {pending, r};
            return;
         end
         for (int a = 0; a < 3; a++) begin
            lo = longint'($signed(bounds_cfg[a][47:24]));
            hi = longint'($signed(bounds_cfg[a][23:0]));
            p[a] = longint'($signed(coord[a]));
            if (p[a] < lo || p[a] > hi) begin
               halted = 1;
               r.status = ST_OUT;
               pending = {pending, r};
               return;
            end
         end
         for (int a = 0; a < 3; a++) begin
            s = (size_cfg[a] == 0) ? 1 : longint'(size_cfg[a]);
            lo = longint'($signed(bounds_cfg[a][47:24]));
            hi = longint'($signed(bounds_cfg[a][23:0]));
            h = floor_div(p[a], s);
            base = h * s;
            n[a] = floor_div(hi, s) - floor_div(lo, s) + 1;
            rel[a] = h - floor_div(lo, s);
            lo_off[a] = 0;
            hi_off[a] = 0;
            if (p[a] - base < longint'(margin_cfg)) lo_off[a] = -1;
            else if (base + s - p[a] < longint'(margin_cfg)) hi_off[a] = 1;
         end
         pn = point_count;
         point_count++;
         for (int dx = lo_off[0]; dx <= hi_off[0]; dx++)
            for (int dy = lo_off[1]; dy <= hi_off[1]; dy++)
               for (int dz = lo_off[2]; dz <= hi_off[2]; dz++) begin
                  ix = rel[0] + dx;
                  iy = rel[1] + dy;
                  iz = rel[2] + dz;
                  if (ix < 0 || ix >= n[0] || iy < 0 || iy >= n[1] || iz < 0 || iz >= n[2])
                     continue;
                  lin = iz * n[1] + iy;
                  if (lin >= GRID) continue;
                  lin = lin * n[0] + ix;
                  if (lin >= GRID) continue;
                  r = '0;
                  r.pn = pn;
                  r.cell_idx = lin[15:0];
                  if (!slot_of.exists(int'(lin))) begin
                     slot_of[int'(lin)] = next_slot;
                     home_count[int'(next_slot)] = 0;
                     next_slot++;
                     r.fresh = 1;
                  end
                  r.slot = 16'(slot_of[int'(lin)]);
                  r.home = (dx == 0 && dy == 0 && dz == 0);
                  if (r.home) begin
                     if (home_count[int'(r.slot)] == 0) r.first = 1;
                     if (home_count[int'(r.slot)] != 32'hFFFF_FFFF)
                        home_count[int'(r.slot)]++;
                  end
                  r.status = ST_OK;
                  cells = {cells, r};
               end
         if (cells.size() > 0) cells[cells.size()-1].last = 1;
         pending = {pending, cells};
      endfunction

      function string check_result(result_type got);
         result_type exp;
         string msg;
         if (pending.size() == 0) return "result with nothing expected";
         exp = pending.pop_front();
         msg = "";
         if (got.pn != exp.pn)
            msg = {msg, $sformatf(" point_number %0d/%0d", got.pn, exp.pn)};
         if (got.cell_idx != exp.cell_idx)
            msg = {msg, $sformatf(" cell_index %0d/%0d", got.cell_idx, exp.cell_idx)};
         if (got.slot != exp.slot)
            msg = {msg, $sformatf(" slot_number %0d/%0d", got.slot, exp.slot)};
         if (got.fresh != exp.fresh)
            msg = {msg, $sformatf(" new_slot %0b/%0b", got.fresh, exp.fresh)};
         if (got.home != exp.home)
            msg = {msg, $sformatf(" home_cell %0b/%0b", got.home, exp.home)};
         if (got.first != exp.first)
            msg = {msg, $sformatf(" first_home_point %0b/%0b", got.first, exp.first)};
         if (got.status != exp.status)
            msg = {msg, $sformatf(" status %0d/%0d", got.status, exp.status)};
         if (got.last != exp.last)
            msg = {msg, $sformatf(" last_result %0b/%0b", got.last, exp.last)};
         return msg;
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [71:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [71:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid = 0;
   logic          csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   binning_scoreboard sb = new();
   int      errors = 0;
   longint  cycles = 0;
   bit      no_idle = 0;
   int      stall_left = 0;

   point_submap_binning_with_margin i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   task report(string msg);
      $display("mismatch at cycle %0d:%s", cycles, msg);
      errors++;
   endtask

   function int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type got;
      string msg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pn       = rsp_tdata[31:0];
         got.cell_idx = rsp_tdata[47:32];
         got.slot     = rsp_tdata[63:48];
         got.fresh    = rsp_tdata[64];
         got.home     = rsp_tdata[65];
         got.first    = rsp_tdata[66];
         got.status   = rsp_tuser;
         got.last     = rsp_tlast;
         msg = sb.check_result(got);
         if (msg != "") report(msg);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 0;
      end else if (no_idle) begin
         rsp_tready <= 1;
      end else begin
         stall_left = pick_gap();
         rsp_tready <= (stall_left == 0);
      end
   end

   task send_point(int x, int y, int z);
      bit [23:0] coord [3];
      int g;
      coord[0] = x[23:0];
      coord[1] = y[23:0];
      coord[2] = z[23:0];
      g = pick_gap();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {coord[2], coord[1], coord[0]};
      do @(posedge clock); while (!req_tready);
      sb.note_point(coord);
   endtask

   task drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_reg(reg_index_type idx, bit [47:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function bit [47:0] bounds(int lo, int hi);
      return {lo[23:0], hi[23:0]};
   endfunction

   task setup(int sx, int sy, int sz, int margin, int lo, int hi);
      write_reg(REG_SIZE_X, 48'(sx));
      write_reg(REG_SIZE_Y, 48'(sy));
      write_reg(REG_SIZE_Z, 48'(sz));
      write_reg(REG_MARGIN, 48'(margin));
      write_reg(REG_BOUNDS_X, bounds(lo, hi));
      write_reg(REG_BOUNDS_Y, bounds(lo, hi));
      write_reg(REG_BOUNDS_Z, bounds(lo, hi));
   endtask

   function int rand_in(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      // reset settings: grid of one cell at the origin
      send_point(0, 0, 0);
      send_point(0, 0, 0);
      drain();

      setup(1280, 1280, 1280, 128, -2560, 2559);
      send_point(-2560, -2560, -2560);
      send_point(2559, 2559, 2559);
      send_point(0, 0, 0);
      send_point(1279, 1279, 1279);
      send_point(-1, -1, -1);
      send_point(640, 640, 640);
      send_point(1200, 100, -100);
      send_point(0, 0, 0);
      for (int i = 0; i < 120; i++) begin
         if (i == 60) drain();
         no_idle = (i >= 80 && i < 100);
         send_point(rand_in(-2560, 2559), rand_in(-2560, 2559), rand_in(-2560, 2559));
      end
      no_idle = 0;
      drain();

      // zero size and full range: only cells near the lower corner fit the table
      setup(0, 0, 0, 0, -8388608, 8388607);
      send_point(-8388608, -8388608, -8388608);
      send_point(8388607, 8388607, 8388607);
      send_point(0, 0, 0);
      send_point(-8388607, -8388608, -8388606);
      drain();

      // margin not below the cell size
      setup(65535, 65535, 65535, 65535, -8388608, 8388607);
      send_point(-8388608, -8388608, -8388608);
      send_point(8388607, 8388607, 8388607);
      send_point(65535, 0, -65535);
      drain();

      write_reg(REG_MARGIN, 48'd300);
      write_reg(REG_SIZE_X, 48'd700);
      for (int i = 0; i < 60; i++) begin
         if (i % 3 == 0)
            send_point(rand_in(-8388608, -8388608 + 200000), rand_in(-8388608, -8388300),
                       rand_in(-8388608, -8388000));
         else
            send_point(int'($urandom()), int'($urandom()), int'($urandom()));
      end
      drain();

      // reversed bounds put every point out of range and halt the block
      write_reg(REG_BOUNDS_Z, bounds(100, -100));
      send_point(0, 0, 0);
      for (int i = 0; i < 8; i++)
         send_point(int'($urandom()), int'($urandom()), int'($urandom()));
      drain();

      if (errors == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
